// ===== hw/rtl/mp4bw_pkg.sv =====
// Shared types and constants for the MP4 box header walker.
// Holds box type codes, mvhd field offsets, the parse phase type and the result record.
// No dependencies.
package mp4bw_pkg;

  localparam logic [31:0] BOX_FTYP = 32'h6674_7970;
  localparam logic [31:0] BOX_MOOV = 32'h6D6F_6F76;
  localparam logic [31:0] BOX_MVHD = 32'h6D76_6864;
  localparam logic [31:0] BOX_TRAK = 32'h7472_616B;

  // Box header length in bytes (size word plus type word).
  localparam logic [31:0] HDR_LEN      = 32'd8;
  localparam logic [7:0]  HDR_LEN_B    = 8'd8;
  // Bytes between the end of duration and the start of the next track identifier.
  localparam logic [7:0]  MVHD_GAP     = 8'd76;

  // Offsets of the last byte of each mvhd field, counted from the version byte.
  localparam logic [7:0]  TS_END_V0    = 8'd15;
  localparam logic [7:0]  TS_END_V1    = 8'd23;
  localparam logic [7:0]  DUR_END_V0   = 8'd19;
  localparam logic [7:0]  DUR_END_V1   = 8'd31;
  localparam logic [7:0]  NT_END_V0    = DUR_END_V0 + MVHD_GAP + 8'd4;
  localparam logic [7:0]  NT_END_V1    = DUR_END_V1 + MVHD_GAP + 8'd4;
  localparam logic [7:0]  MVHD_VER_1   = 8'd1;
  localparam logic [7:0]  OFFSET_MAX   = 8'd255;

  typedef enum logic [1:0] {
    EV_TOP_HDR   = 2'd0,
    EV_CHILD_HDR = 2'd1,
    EV_MVHD      = 2'd2,
    EV_SIZE_ERR  = 2'd3
  } event_kind_t;

  typedef enum logic [4:0] {
    PH_TOP        = 5'b00001,
    PH_SKIP_TOP   = 5'b00010,
    PH_CHILD      = 5'b00100,
    PH_MVHD       = 5'b01000,
    PH_SKIP_CHILD = 5'b10000
  } phase_t;

  typedef struct packed {
    event_kind_t  event_kind;
    logic [31:0]  box_size;
    logic [31:0]  box_type;
    logic [7:0]   mvhd_version;
    logic [31:0]  time_scale;
    logic [63:0]  duration;
    logic [31:0]  next_track;
  } result_t;

endpackage

// ===== hw/rtl/mp4bw_parse.sv =====
// Byte parser of the MP4 box header walker: phase, byte counters and mvhd capture.
// Produces at most one result per accepted byte, combinationally from the state registers and the byte.
// Depends on mp4bw_pkg.
module mp4bw_parse #(
  parameter int SIZE_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  output logic              res_valid,
  output mp4bw_pkg::result_t res
);
  import mp4bw_pkg::*;

  localparam int CW = SIZE_BITS;

  phase_t          phase_r, phase_nxt;
  logic [CW-1:0]   top_left_r, top_left_nxt;
  logic [CW-1:0]   child_left_r, child_left_nxt;
  logic [CW-1:0]   moov_left_r, moov_left_nxt;
  logic [63:0]     shift_r, shift_nxt;
  logic [7:0]      offset_r, offset_nxt;
  logic [7:0]      ver_r, ver_nxt;
  logic [31:0]     ts_r, ts_nxt;
  logic [63:0]     dur_r, dur_nxt;
  logic            err_stop_r, err_stop_nxt;

  logic [63:0]     shift_in;
  logic [31:0]     hdr_size;
  logic [31:0]     hdr_type;
  logic            hdr_small;
  logic [31:0]     rem32;
  logic [63:0]     rem_wide;
  logic            rem_over;
  logic [CW-1:0]   rem_cnt;
  logic [7:0]      offset_inc;
  logic [7:0]      ver_cur;
  logic            v1;
  logic [CW-1:0]   top_dec;
  logic [CW-1:0]   child_dec;
  logic [CW-1:0]   moov_dec;
  logic            moov_step;

  assign shift_in   = {shift_r[55:0], data_byte};
  assign hdr_size   = shift_in[63:32];
  assign hdr_type   = shift_in[31:0];
  assign hdr_small  = hdr_size < HDR_LEN;
  assign rem32      = hdr_size - HDR_LEN;
  assign rem_wide   = {32'd0, rem32};
  // A payload length beyond the counter range is clamped to all ones.
  assign rem_over   = (CW < 32) && ((rem32 >> CW) != 32'd0);
  assign rem_cnt    = rem_over ? '1 : rem_wide[CW-1:0];
  assign offset_inc = offset_r + 8'd1;
  assign top_dec    = (top_left_r != '0) ? top_left_r - CW'(1) : top_left_r;
  assign child_dec  = (child_left_r != '0) ? child_left_r - CW'(1) : child_left_r;
  assign moov_dec   = (moov_left_r != '0) ? moov_left_r - CW'(1) : moov_left_r;
  assign ver_cur    = (offset_r == 8'd0) ? data_byte : ver_r;
  assign v1         = ver_cur == MVHD_VER_1;

  always_comb begin
    phase_nxt      = phase_r;
    top_left_nxt   = top_left_r;
    child_left_nxt = child_left_r;
    moov_left_nxt  = moov_left_r;
    shift_nxt      = shift_r;
    offset_nxt     = offset_r;
    ver_nxt        = ver_r;
    ts_nxt         = ts_r;
    dur_nxt        = dur_r;
    err_stop_nxt   = err_stop_r;
    res_valid      = 1'b0;
    res            = '0;
    moov_step      = 1'b1;

    if (accept && !err_stop_r) begin
      unique case (phase_r)
        PH_SKIP_TOP: begin
          top_left_nxt = top_dec;
          if (top_dec == '0) begin
            phase_nxt = PH_TOP;
          end
        end
        PH_CHILD, PH_MVHD, PH_SKIP_CHILD: begin
          if (phase_r == PH_CHILD) begin
            shift_nxt  = shift_in;
            offset_nxt = offset_inc;
            if (offset_inc >= HDR_LEN_B) begin
              offset_nxt   = 8'd0;
              res_valid    = 1'b1;
              res.box_size = hdr_size;
              res.box_type = hdr_type;
              if (hdr_small) begin
                // A bad child size stops the walker before the moov count moves.
                res.event_kind = EV_SIZE_ERR;
                err_stop_nxt   = 1'b1;
                phase_nxt      = PH_TOP;
                moov_step      = 1'b0;
              end else begin
                res.event_kind = EV_CHILD_HDR;
                child_left_nxt = rem_cnt;
                if (rem_cnt == '0) begin
                  phase_nxt = PH_CHILD;
                end else if (hdr_type == BOX_MVHD) begin
                  phase_nxt = PH_MVHD;
                end else begin
                  phase_nxt = PH_SKIP_CHILD;
                end
              end
            end
          end else begin
            if (phase_r == PH_MVHD) begin
              shift_nxt = shift_in;
              if (offset_r == 8'd0) begin
                ver_nxt = data_byte;
                ts_nxt  = 32'd0;
              end
              if (offset_r == (v1 ? TS_END_V1 : TS_END_V0)) begin
                ts_nxt = shift_in[31:0];
              end
              if (offset_r == (v1 ? DUR_END_V1 : DUR_END_V0)) begin
                dur_nxt = v1 ? shift_in : {32'd0, shift_in[31:0]};
              end
              if (offset_r == (v1 ? NT_END_V1 : NT_END_V0)) begin
                res_valid        = 1'b1;
                res.event_kind   = EV_MVHD;
                res.mvhd_version = ver_r;
                res.time_scale   = ts_r;
                res.duration     = dur_r;
                res.next_track   = shift_in[31:0];
              end
              if (offset_r < OFFSET_MAX) begin
                offset_nxt = offset_inc;
              end
            end
            child_left_nxt = child_dec;
            if (child_dec == '0) begin
              phase_nxt  = PH_CHILD;
              offset_nxt = 8'd0;
            end
          end
          // The end of the moov payload returns to top level, even mid child.
          if (moov_step) begin
            moov_left_nxt = moov_dec;
            if (moov_dec == '0) begin
              phase_nxt  = PH_TOP;
              offset_nxt = 8'd0;
            end
          end
        end
        default: begin
          shift_nxt  = shift_in;
          offset_nxt = offset_inc;
          phase_nxt  = PH_TOP;
          if (offset_inc >= HDR_LEN_B) begin
            offset_nxt   = 8'd0;
            res_valid    = 1'b1;
            res.box_size = hdr_size;
            res.box_type = hdr_type;
            if (hdr_small) begin
              res.event_kind = EV_SIZE_ERR;
              err_stop_nxt   = 1'b1;
            end else begin
              res.event_kind = EV_TOP_HDR;
              if (hdr_type == BOX_MOOV) begin
                moov_left_nxt = rem_cnt;
                phase_nxt     = (rem_cnt != '0) ? PH_CHILD : PH_TOP;
              end else begin
                top_left_nxt = rem_cnt;
                phase_nxt    = (rem_cnt != '0) ? PH_SKIP_TOP : PH_TOP;
              end
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_TOP;
      top_left_r   <= '0;
      child_left_r <= '0;
      moov_left_r  <= '0;
      shift_r      <= '0;
      offset_r     <= '0;
      ver_r        <= '0;
      ts_r         <= '0;
      dur_r        <= '0;
      err_stop_r   <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      top_left_r   <= top_left_nxt;
      child_left_r <= child_left_nxt;
      moov_left_r  <= moov_left_nxt;
      shift_r      <= shift_nxt;
      offset_r     <= offset_nxt;
      ver_r        <= ver_nxt;
      ts_r         <= ts_nxt;
      dur_r        <= dur_nxt;
      err_stop_r   <= err_stop_nxt;
    end
  end

endmodule

// ===== hw/rtl/mp4bw_out_buf.sv =====
// Result register with a one-entry skid stage for the MP4 box header walker.
// Holds finished results until the receiver takes them; stalls input only when the skid is full.
// Depends on mp4bw_pkg.
module mp4bw_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mp4bw_pkg::result_t push_res,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output mp4bw_pkg::result_t out_res
);
  import mp4bw_pkg::*;

  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_res_r, out_res_nxt;
  result_t skid_res_r, skid_res_nxt;
  logic    take;

  assign take      = out_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    out_valid_nxt  = out_valid_r && !take;
    skid_valid_nxt = skid_valid_r;
    out_res_nxt    = out_res_r;
    skid_res_nxt   = skid_res_r;
    if (skid_valid_r) begin
      // No push can arrive while the skid holds a result.
      if (take) begin
        out_res_nxt    = skid_res_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || take) begin
        out_res_nxt   = push_res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_res_nxt   = push_res;
        skid_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

endmodule

// ===== hw/rtl/mp4_box_header_walker.sv =====
// Top level of the MP4 box header walker.
// Instantiates the byte parser mp4bw_parse and the result buffer mp4bw_out_buf.
// Depends on mp4bw_pkg.
//
// Usage: feed the file one byte per transfer on the in_ channel (in_valid,
// in_stall, in_data_byte). Each top-level box header gives one result of
// kind top header, each child header inside moov gives a child header result,
// a complete mvhd gives its version, timescale, duration and next track ID,
// and a box size below 8 gives a size error result, after which every byte is
// taken and ignored until reset.
// Throughput is one byte per cycle while in_stall is low: the parser updates
// its counters and its header shift register once for each accepted byte.
// A result is formed combinationally from the byte that completes it and is
// registered in the out_ channel register, or in the skid stage when stalled.
// When the receiver asserts out_stall, the output register holds its result
// and one more result can land in the skid stage; in_stall rises only while
// the skid stage is occupied.
// Reset (rst_n low, synchronous) returns the parser to the top header phase
// with all counters cleared and empties both result stages.
module mp4_box_header_walker #(
  parameter int SIZE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_event_kind,
  output logic [31:0] out_box_size,
  output logic [31:0] out_box_type,
  output logic [7:0]  out_mvhd_version,
  output logic [31:0] out_time_scale,
  output logic [63:0] out_duration,
  output logic [31:0] out_next_track
);
  import mp4bw_pkg::*;

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_res;
  logic    buf_full;

  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  mp4bw_parse #(
    .SIZE_BITS(SIZE_BITS)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_data_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  mp4bw_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_res  (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_event_kind   = out_res.event_kind;
  assign out_box_size     = out_res.box_size;
  assign out_box_type     = out_res.box_type;
  assign out_mvhd_version = out_res.mvhd_version;
  assign out_time_scale   = out_res.time_scale;
  assign out_duration     = out_res.duration;
  assign out_next_track   = out_res.next_track;

endmodule
